// File: src/hrd_pkg.sv
`default_nettype none

package hrd_pkg;

    typedef enum logic [6:0] {
        PH_STATUS  = 7'b0000001,
        PH_INTERIM = 7'b0000010,
        PH_HEADERS = 7'b0000100,
        PH_BODY    = 7'b0001000,
        PH_CSIZE   = 7'b0010000,
        PH_CDATA   = 7'b0100000,
        PH_FOOTERS = 7'b1000000
    } phase_t;

    // line_kind codes
    localparam logic [2:0] LK_START = 3'd0;
    localparam logic [2:0] LK_ONE   = 3'd1;
    localparam logic [2:0] LK_TWO   = 3'd2;
    localparam logic [2:0] LK_TAIL  = 3'd3;
    localparam logic [2:0] LK_BAD   = 3'd4;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_BODY   = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    localparam logic ERR_PROTOCOL = 1'b0;
    localparam logic ERR_TOO_MUCH = 1'b1;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [31:0] BODY_LIMIT_RESET = 32'd16777216;

    localparam logic [8*7-1:0]  STATUS_PREFIX = "HTTP/1.";
    localparam logic [8*14-1:0] NAME_LENGTH   = "Content-Length";
    localparam logic [8*17-1:0] NAME_ENCODING = "Transfer-Encoding";
    localparam logic [8*7-1:0]  SPELL_LOWER   = "chunked";
    localparam logic [8*7-1:0]  SPELL_CAP     = "Chunked";
    localparam logic [8*7-1:0]  SPELL_UPPER   = "CHUNKED";

    typedef struct packed {
        phase_t      phase;
        logic [4:0]  line_pos;
        logic [2:0]  line_kind;
        logic        cr_pending;
        logic        line_empty;
        logic [15:0] status_acc;
        logic        minor;
        logic [1:0]  key_match;
        logic        value_ok;
        logic [2:0]  spell;
        logic        length_valid;
        logic        chunked;
        logic        finished;
    } ctl_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [7:0]  data;
        logic        last;
        logic [15:0] code;
        logic        minor;
        logic        err;
    } result_t;

    function automatic logic is_ws(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0b || c == 8'h0c || c == 8'h0d;
    endfunction

    function automatic logic is_dec(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        t = 8'h00;
        if (c >= "0" && c <= "9") begin
            t = c - 8'h30;
            return {1'b1, t[3:0]};
        end
        if (c >= "a" && c <= "f") begin
            t = c - 8'h57;
            return {1'b1, t[3:0]};
        end
        if (c >= "A" && c <= "F") begin
            t = c - 8'h37;
            return {1'b1, t[3:0]};
        end
        return 5'd0;
    endfunction

    function automatic logic [7:0] char7(input logic [8*7-1:0] s, input logic [4:0] p);
        logic [2:0] i;
        i = 3'd6 - p[2:0];
        if (p < 5'd7)
            return s[8*i +: 8];
        return 8'h00;
    endfunction

    function automatic logic [7:0] char_len(input logic [4:0] p);
        logic [3:0] i;
        i = 4'd13 - p[3:0];
        if (p < 5'd14)
            return NAME_LENGTH[8*i +: 8];
        return 8'h00;
    endfunction

    function automatic logic [7:0] char_enc(input logic [4:0] p);
        logic [4:0] i;
        i = 5'd16 - p;
        if (p < 5'd17)
            return NAME_ENCODING[8*i +: 8];
        return 8'h00;
    endfunction

endpackage

`default_nettype wire

// File: src/http_response_deframer_top.sv
// A result is registered and appears on the output in the cycle after its input request is accepted.
// Throughput: one input request per cycle; each byte passes one register stage.
// The output register stalls input only while a held result is not taken.
// Reset (rst_n low, asynchronous): parser waits for a status line, body_limit = 16777216.
`default_nettype none

module http_response_deframer_top
    import hrd_pkg::*;
#(
    parameter int LEN_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        func,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [7:0]       body_byte,
    output logic             body_last,
    output logic [15:0]      status_code,
    output logic             http_minor,
    output logic             error_code
);

    logic [31:0] limit_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    result_t     res;
    logic        step;

    assign in_ready  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;
    assign step      = in_valid && in_ready;

    hrd_core #(
        .LEN_BITS (LEN_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .func       (func),
        .rx_byte    (rx_byte),
        .body_limit (limit_reg),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= BODY_LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                limit_reg <= cfg_data;
            if (in_ready)
                out_valid_reg <= step && res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res.valid)
            out_reg <= res;
    end

    assign out_valid   = out_valid_reg;
    assign kind        = out_reg.kind;
    assign body_byte   = out_reg.data;
    assign body_last   = out_reg.last;
    assign status_code = out_reg.code;
    assign http_minor  = out_reg.minor;
    assign error_code  = out_reg.err;

endmodule

`default_nettype wire

// File: src/hrd_core.sv
`default_nettype none

module hrd_core
    import hrd_pkg::*;
#(
    parameter int LEN_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic        func,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [31:0] body_limit,
    output result_t          res
);

    localparam int CW = (LEN_BITS > 32) ? LEN_BITS : 32;

    ctl_t                ctl_reg, ctl_next;
    logic [LEN_BITS-1:0] value_reg, value_next;
    logic [LEN_BITS-1:0] length_reg, length_next;
    logic [LEN_BITS-1:0] left_reg, left_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg            <= '0;
            ctl_reg.phase      <= PH_STATUS;
            ctl_reg.line_empty <= 1'b1;
            ctl_reg.key_match  <= 2'b11;
            value_reg          <= '0;
            length_reg         <= '0;
            left_reg           <= '0;
        end
        else
        begin
            ctl_reg    <= ctl_next;
            value_reg  <= value_next;
            length_reg <= length_next;
            left_reg   <= left_next;
        end
    end

    always_comb
    begin
        logic [7:0]          c;
        logic                do_end;
        logic                do_content;
        logic                skip;
        logic [4:0]          hx;
        logic [LEN_BITS+3:0] dec_w;
        logic [19:0]         st_w;
        logic [CW-1:0]       lim_w;
        logic [CW-1:0]       cmp_w;
        logic                line_reset;

        c          = rx_byte;
        ctl_next   = ctl_reg;
        value_next = value_reg;
        length_next = length_reg;
        left_next  = left_reg;
        res        = '0;
        do_end     = 1'b0;
        do_content = 1'b0;
        skip       = 1'b0;
        hx         = hex_val(c);
        dec_w      = '0;
        st_w       = '0;
        lim_w      = CW'(body_limit);
        cmp_w      = '0;
        line_reset = 1'b0;

        if (step)
        begin
            if (func)
            begin
                ctl_next              = '0;
                ctl_next.phase        = PH_STATUS;
                ctl_next.line_empty   = 1'b1;
                ctl_next.key_match    = 2'b11;
                value_next            = '0;
                length_next           = '0;
                left_next             = '0;
            end
            else if (!ctl_reg.finished)
            begin
                if (ctl_reg.phase == PH_BODY)
                begin
                    left_next = left_reg - LEN_BITS'(1);
                    res.valid = 1'b1;
                    res.kind  = KIND_BODY;
                    res.data  = c;
                    res.last  = (left_reg == LEN_BITS'(1));
                    if (left_reg == LEN_BITS'(1))
                        ctl_next.finished = 1'b1;
                end
                else if (ctl_reg.phase == PH_CDATA)
                begin
                    left_next = left_reg - LEN_BITS'(1);
                    res.valid = 1'b1;
                    res.kind  = KIND_BODY;
                    res.data  = c;
                    if (left_reg == LEN_BITS'(1))
                    begin
                        ctl_next.phase = PH_CSIZE;
                        line_reset     = 1'b1;
                    end
                end
                else if (c == 8'h00)
                begin
                    ctl_next.finished = 1'b1;
                    res.valid = 1'b1;
                    res.kind  = KIND_ERROR;
                    res.err   = ERR_PROTOCOL;
                end
                else
                begin
                    if (ctl_reg.cr_pending)
                    begin
                        ctl_next.cr_pending = 1'b0;
                        if (c == CH_LF)
                            do_end = 1'b1;
                        else
                        begin
                            // a lone CR taken as a line character
                            ctl_next.line_empty = 1'b0;
                            case (ctl_next.phase)
                                PH_STATUS:
                                begin
                                    if (ctl_next.line_kind == LK_START)
                                        ctl_next.line_kind = LK_BAD;
                                    else if (ctl_next.line_kind == LK_TWO)
                                        ctl_next.line_kind = LK_TAIL;
                                end
                                PH_HEADERS:
                                begin
                                    if (ctl_next.line_kind == LK_START)
                                    begin
                                        ctl_next.key_match = 2'b00;
                                    end
                                    else
                                    begin
                                        if (ctl_next.line_kind == LK_ONE)
                                        begin
                                            ctl_next.line_kind = LK_TWO;
                                            ctl_next.line_pos  = 5'd0;
                                            value_next         = '0;
                                        end
                                        ctl_next.value_ok = 1'b0;
                                        ctl_next.spell    = 3'b000;
                                    end
                                    if (ctl_next.line_pos < 5'd31)
                                        ctl_next.line_pos = ctl_next.line_pos + 5'd1;
                                end
                                PH_CSIZE:
                                begin
                                    if (ctl_next.line_kind == LK_ONE ||
                                        ctl_next.line_kind == LK_TWO)
                                        ctl_next.line_kind = LK_TAIL;
                                end
                                default: ;
                            endcase
                        end
                    end
                    if (!do_end)
                    begin
                        if (c == CH_CR)
                            ctl_next.cr_pending = 1'b1;
                        else if (c == CH_LF)
                            do_end = 1'b1;
                        else
                            do_content = 1'b1;
                    end

                    if (do_content)
                    begin
                        ctl_next.line_empty = 1'b0;
                        case (ctl_next.phase)
                            PH_STATUS:
                            begin
                                case (ctl_next.line_kind)
                                    LK_START:
                                    begin
                                        if (ctl_next.line_pos < 5'd7)
                                        begin
                                            if (c == char7(STATUS_PREFIX, ctl_next.line_pos))
                                                ctl_next.line_pos = ctl_next.line_pos + 5'd1;
                                            else
                                                ctl_next.line_kind = LK_BAD;
                                        end
                                        else if (c == "0" || c == "1")
                                        begin
                                            ctl_next.minor     = c[0];
                                            ctl_next.line_kind = LK_ONE;
                                        end
                                        else
                                            ctl_next.line_kind = LK_BAD;
                                    end
                                    LK_ONE:
                                    begin
                                        if (is_dec(c))
                                        begin
                                            ctl_next.status_acc = {12'd0, hx[3:0]};
                                            ctl_next.line_kind  = LK_TWO;
                                        end
                                        else if (!is_ws(c))
                                            ctl_next.line_kind = LK_BAD;
                                    end
                                    LK_TWO:
                                    begin
                                        if (is_dec(c))
                                        begin
                                            st_w = 20'(ctl_next.status_acc) * 20'd10
                                                 + 20'(hx[3:0]);
                                            ctl_next.status_acc = (st_w[19:16] != 4'd0)
                                                ? 16'hffff : st_w[15:0];
                                        end
                                        else
                                            ctl_next.line_kind = LK_TAIL;
                                    end
                                    default: ;
                                endcase
                            end
                            PH_HEADERS:
                            begin
                                if (ctl_next.line_kind == LK_START)
                                begin
                                    if (c == CH_COLON)
                                    begin
                                        ctl_next.key_match = ctl_next.key_match &
                                            {ctl_next.line_pos == 5'd17,
                                             ctl_next.line_pos == 5'd14};
                                        ctl_next.line_kind = LK_ONE;
                                        ctl_next.line_pos  = 5'd0;
                                    end
                                    else
                                    begin
                                        if (c != char_len(ctl_next.line_pos))
                                            ctl_next.key_match[0] = 1'b0;
                                        if (c != char_enc(ctl_next.line_pos))
                                            ctl_next.key_match[1] = 1'b0;
                                        if (ctl_next.line_pos < 5'd31)
                                            ctl_next.line_pos = ctl_next.line_pos + 5'd1;
                                    end
                                end
                                else
                                begin
                                    if (ctl_next.line_kind == LK_ONE)
                                    begin
                                        if (c == CH_SPACE)
                                            skip = 1'b1;
                                        else
                                        begin
                                            ctl_next.line_kind = LK_TWO;
                                            ctl_next.value_ok  = 1'b1;
                                            ctl_next.spell     = 3'b111;
                                            ctl_next.line_pos  = 5'd0;
                                            value_next         = '0;
                                        end
                                    end
                                    if (!skip)
                                    begin
                                        if (is_dec(c) && ctl_next.value_ok)
                                        begin
                                            dec_w = (LEN_BITS+4)'(value_next)
                                                  * (LEN_BITS+4)'(10)
                                                  + (LEN_BITS+4)'(hx[3:0]);
                                            value_next = (dec_w[LEN_BITS+3:LEN_BITS] != 4'd0)
                                                ? '1 : dec_w[LEN_BITS-1:0];
                                        end
                                        else
                                            ctl_next.value_ok = 1'b0;
                                        if (c != char7(SPELL_LOWER, ctl_next.line_pos))
                                            ctl_next.spell[0] = 1'b0;
                                        if (c != char7(SPELL_CAP, ctl_next.line_pos))
                                            ctl_next.spell[1] = 1'b0;
                                        if (c != char7(SPELL_UPPER, ctl_next.line_pos))
                                            ctl_next.spell[2] = 1'b0;
                                        if (ctl_next.line_pos < 5'd31)
                                            ctl_next.line_pos = ctl_next.line_pos + 5'd1;
                                    end
                                end
                            end
                            PH_CSIZE:
                            begin
                                case (ctl_next.line_kind)
                                    LK_START:
                                    begin
                                        if (c == "0")
                                        begin
                                            value_next         = '0;
                                            ctl_next.line_kind = LK_ONE;
                                        end
                                        else if (hx[4])
                                        begin
                                            value_next         = LEN_BITS'(hx[3:0]);
                                            ctl_next.line_kind = LK_TWO;
                                        end
                                        else if (!is_ws(c))
                                            ctl_next.line_kind = LK_BAD;
                                    end
                                    LK_ONE:
                                    begin
                                        if (c == "x" || c == "X")
                                            ctl_next.line_kind = LK_TWO;
                                        else if (hx[4])
                                        begin
                                            value_next         = LEN_BITS'(hx[3:0]);
                                            ctl_next.line_kind = LK_TWO;
                                        end
                                        else
                                            ctl_next.line_kind = LK_TAIL;
                                    end
                                    LK_TWO:
                                    begin
                                        if (hx[4])
                                            value_next = (value_next[LEN_BITS-1 -: 4] != 4'd0)
                                                ? '1 : {value_next[LEN_BITS-5:0], hx[3:0]};
                                        else
                                            ctl_next.line_kind = LK_TAIL;
                                    end
                                    default: ;
                                endcase
                            end
                            default: ;
                        endcase
                    end

                    if (do_end)
                    begin
                        line_reset = 1'b1;
                        unique case (ctl_next.phase)
                            PH_STATUS:
                            begin
                                if (ctl_next.line_kind != LK_TWO &&
                                    ctl_next.line_kind != LK_TAIL)
                                begin
                                    line_reset        = 1'b0;
                                    ctl_next.finished = 1'b1;
                                    res.valid = 1'b1;
                                    res.kind  = KIND_ERROR;
                                    res.err   = ERR_PROTOCOL;
                                end
                                else if (ctl_next.status_acc == 16'd100)
                                    ctl_next.phase = PH_INTERIM;
                                else
                                begin
                                    ctl_next.phase = PH_HEADERS;
                                    res.valid = 1'b1;
                                    res.kind  = KIND_STATUS;
                                    res.code  = ctl_next.status_acc;
                                    res.minor = ctl_next.minor;
                                end
                            end
                            PH_INTERIM:
                            begin
                                if (ctl_next.line_empty)
                                    ctl_next.phase = PH_STATUS;
                            end
                            PH_HEADERS:
                            begin
                                cmp_w = CW'(length_next);
                                if (!ctl_next.line_empty)
                                begin
                                    if (ctl_next.line_kind != LK_TWO)
                                    begin
                                        line_reset        = 1'b0;
                                        ctl_next.finished = 1'b1;
                                        res.valid = 1'b1;
                                        res.kind  = KIND_ERROR;
                                        res.err   = ERR_PROTOCOL;
                                    end
                                    else if (ctl_next.key_match == 2'b01)
                                    begin
                                        length_next           = value_next;
                                        ctl_next.length_valid = ctl_next.value_ok;
                                    end
                                    else if (ctl_next.key_match == 2'b10)
                                        ctl_next.chunked = (ctl_next.spell != 3'b000) &&
                                                           (ctl_next.line_pos == 5'd7);
                                end
                                else if (ctl_next.chunked)
                                    ctl_next.phase = PH_CSIZE;
                                else
                                begin
                                    line_reset = 1'b0;
                                    res.valid  = 1'b1;
                                    if (!ctl_next.length_valid)
                                    begin
                                        ctl_next.finished = 1'b1;
                                        res.kind = KIND_ERROR;
                                        res.err  = ERR_PROTOCOL;
                                    end
                                    else if (cmp_w > lim_w)
                                    begin
                                        ctl_next.finished = 1'b1;
                                        res.kind = KIND_ERROR;
                                        res.err  = ERR_TOO_MUCH;
                                    end
                                    else if (length_next == '0)
                                    begin
                                        ctl_next.finished = 1'b1;
                                        res.kind = KIND_DONE;
                                    end
                                    else
                                    begin
                                        res.valid      = 1'b0;
                                        line_reset     = 1'b1;
                                        ctl_next.phase = PH_BODY;
                                        left_next      = length_next;
                                    end
                                end
                            end
                            PH_CSIZE:
                            begin
                                cmp_w = CW'(value_next);
                                if (!ctl_next.line_empty)
                                begin
                                    if (ctl_next.line_kind == LK_START ||
                                        ctl_next.line_kind == LK_BAD)
                                    begin
                                        line_reset        = 1'b0;
                                        ctl_next.finished = 1'b1;
                                        res.valid = 1'b1;
                                        res.kind  = KIND_ERROR;
                                        res.err   = ERR_PROTOCOL;
                                    end
                                    else if (cmp_w > lim_w)
                                    begin
                                        line_reset        = 1'b0;
                                        ctl_next.finished = 1'b1;
                                        res.valid = 1'b1;
                                        res.kind  = KIND_ERROR;
                                        res.err   = ERR_TOO_MUCH;
                                    end
                                    else if (value_next == '0)
                                        ctl_next.phase = PH_FOOTERS;
                                    else
                                    begin
                                        ctl_next.phase = PH_CDATA;
                                        left_next      = value_next;
                                    end
                                end
                            end
                            default:
                            begin
                                if (ctl_next.line_empty)
                                begin
                                    line_reset        = 1'b0;
                                    ctl_next.finished = 1'b1;
                                    res.valid = 1'b1;
                                    res.kind  = KIND_DONE;
                                end
                            end
                        endcase
                    end
                end

                if (line_reset)
                begin
                    ctl_next.line_pos   = 5'd0;
                    ctl_next.line_kind  = LK_START;
                    ctl_next.line_empty = 1'b1;
                    ctl_next.cr_pending = 1'b0;
                    ctl_next.key_match  = 2'b11;
                    ctl_next.value_ok   = 1'b0;
                    ctl_next.spell      = 3'b000;
                    ctl_next.status_acc = 16'd0;
                    value_next          = '0;
                end
            end
        end
    end

    a_quiet_when_finished: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.finished && step && !func |-> !res.valid)
        else $error("result after completion");

    a_body_in_data_phase: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.kind == KIND_BODY |->
            ctl_reg.phase == PH_BODY || ctl_reg.phase == PH_CDATA)
        else $error("body byte outside data phase");

    a_last_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.last |=> ctl_reg.finished)
        else $error("last body byte did not finish response");

endmodule

`default_nettype wire

// File: tb/sv/http_response_deframer_checker.sv
`timescale 1ns / 100ps
`default_nettype none

module http_response_deframer_checker
    import hrd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic        func,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [31:0] cfg_data,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [1:0]  kind,
    input  wire logic [7:0]  body_byte,
    input  wire logic        body_last,
    input  wire logic [15:0] status_code,
    input  wire logic        http_minor,
    input  wire logic        error_code,
    output int               errors,
    output int               pending,
    output int               checked
);

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic        last;
        logic [15:0] code;
        logic        minor;
        logic        err;
    } deframe_out_t;

    localparam logic [31:0] LEN_MAX = 32'hFFFF_FFFF;

    string prefix_txt = "HTTP/1.";
    string len_key    = "Content-Length";
    string enc_key    = "Transfer-Encoding";
    string spell_txt[3] = '{"chunked", "Chunked", "CHUNKED"};

    deframe_out_t expected_q[$];

    logic [31:0] limit;
    phase_t      ph;
    logic [4:0]  lpos;
    logic [2:0]  lk;
    logic        cr, lempty;
    logic [15:0] sacc;
    logic        minor;
    logic [1:0]  km;
    logic [31:0] vacc;
    logic        vok;
    logic [2:0]  spell;
    logic [31:0] lenv;
    logic        lenok, chk, fin;
    logic [31:0] left;

    assign pending = expected_q.size();

    function automatic logic [63:0] sat_acc(input logic [63:0] acc, input int base,
                                            input int d, input logic [63:0] mx);
        if (acc > (mx - d) / base)
            return mx;
        return acc * base + d;
    endfunction

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic logic white(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0b || c == 8'h0c || c == 8'h0d;
    endfunction

    task automatic put(input logic [1:0] k, input logic [7:0] d, input logic l,
                       input logic [15:0] code, input logic mn, input logic e);
        deframe_out_t r;
        r.kind = k; r.data = d; r.last = l; r.code = code; r.minor = mn; r.err = e;
        expected_q.push_back(r);
    endtask

    task automatic fail(input logic e);
        fin = 1'b1;
        put(KIND_ERROR, 8'd0, 1'b0, 16'd0, 1'b0, e);
    endtask

    task automatic line_reset();
        lpos = 0; lk = LK_START; lempty = 1'b1; cr = 1'b0; km = 2'b11;
        vacc = 0; vok = 1'b0; spell = 3'd0; sacc = 16'd0;
    endtask

    task automatic restart_parser();
        ph = PH_STATUS;
        line_reset();
        minor = 1'b0; lenv = 0; lenok = 1'b0; chk = 1'b0; left = 0; fin = 1'b0;
    endtask

    task automatic eat(input logic [7:0] c);
        int h;
        lempty = 1'b0;
        if (ph == PH_STATUS) begin
            if (lk == LK_START) begin
                if (lpos < 7) begin
                    if (c == prefix_txt[lpos]) lpos++;
                    else lk = LK_BAD;
                end else if (c == "0" || c == "1") begin
                    minor = c[0]; lk = LK_ONE;
                end else lk = LK_BAD;
            end else if (lk == LK_ONE) begin
                if (c >= "0" && c <= "9") begin
                    sacc = c - "0"; lk = LK_TWO;
                end else if (!white(c)) lk = LK_BAD;
            end else if (lk == LK_TWO) begin
                if (c >= "0" && c <= "9")
                    sacc = 16'(sat_acc(sacc, 10, c - "0", 64'hFFFF));
                else lk = LK_TAIL;
            end
        end else if (ph == PH_HEADERS) begin
            if (lk == LK_START) begin
                if (c == CH_COLON) begin
                    km &= {lpos == 17, lpos == 14};
                    lk = LK_ONE; lpos = 0;
                    return;
                end
                if (!(lpos < 14 && c == len_key[lpos])) km &= 2'b10;
                if (!(lpos < 17 && c == enc_key[lpos])) km &= 2'b01;
                if (lpos < 31) lpos++;
                return;
            end
            if (lk == LK_ONE) begin
                if (c == CH_SPACE) return;
                lk = LK_TWO; vok = 1'b1; vacc = 0; spell = 3'b111; lpos = 0;
            end
            if (c >= "0" && c <= "9" && vok)
                vacc = 32'(sat_acc(vacc, 10, c - "0", LEN_MAX));
            else vok = 1'b0;
            for (int s = 0; s < 3; s++)
                if (!(lpos < 7 && c == spell_txt[s][lpos])) spell[s] = 1'b0;
            if (lpos < 31) lpos++;
        end else if (ph == PH_CSIZE) begin
            h = hex_digit(c);
            if (lk == LK_START) begin
                if (c == "0") begin vacc = 0; lk = LK_ONE; end
                else if (h >= 0) begin vacc = h; lk = LK_TWO; end
                else if (!white(c)) lk = LK_BAD;
            end else if (lk == LK_ONE) begin
                if (c == "x" || c == "X") lk = LK_TWO;
                else if (h >= 0) begin vacc = h; lk = LK_TWO; end
                else lk = LK_TAIL;
            end else if (lk == LK_TWO) begin
                if (h >= 0) vacc = 32'(sat_acc(vacc, 16, h, LEN_MAX));
                else lk = LK_TAIL;
            end
        end
    endtask

    task automatic end_line();
        case (ph)
            PH_STATUS: begin
                if (lk != LK_TWO && lk != LK_TAIL) begin fail(ERR_PROTOCOL); return; end
                if (sacc == 16'd100) ph = PH_INTERIM;
                else begin
                    ph = PH_HEADERS;
                    put(KIND_STATUS, 8'd0, 1'b0, sacc, minor, 1'b0);
                end
            end
            PH_INTERIM: if (lempty) ph = PH_STATUS;
            PH_HEADERS: begin
                if (!lempty) begin
                    if (lk != LK_TWO) begin fail(ERR_PROTOCOL); return; end
                    if (km == 2'b01) begin lenv = vacc; lenok = vok; end
                    else if (km == 2'b10) chk = (spell != 0 && lpos == 7);
                end else if (chk) ph = PH_CSIZE;
                else if (!lenok) begin fail(ERR_PROTOCOL); return; end
                else if (lenv > limit) begin fail(ERR_TOO_MUCH); return; end
                else if (lenv == 0) begin
                    fin = 1'b1;
                    put(KIND_DONE, 8'd0, 1'b0, 16'd0, 1'b0, 1'b0);
                    return;
                end else begin
                    ph = PH_BODY; left = lenv;
                end
            end
            PH_CSIZE: begin
                if (!lempty) begin
                    if (lk == LK_START || lk == LK_BAD) begin fail(ERR_PROTOCOL); return; end
                    if (vacc > limit) begin fail(ERR_TOO_MUCH); return; end
                    if (vacc == 0) ph = PH_FOOTERS;
                    else begin ph = PH_CDATA; left = vacc; end
                end
            end
            default: begin
                if (lempty) begin
                    fin = 1'b1;
                    put(KIND_DONE, 8'd0, 1'b0, 16'd0, 1'b0, 1'b0);
                    return;
                end
            end
        endcase
        line_reset();
    endtask

    task automatic take_request(input logic f, input logic [7:0] c);
        if (f) begin restart_parser(); return; end
        if (fin) return;
        if (ph == PH_BODY) begin
            put(KIND_BODY, c, left == 1, 16'd0, 1'b0, 1'b0);
            if (left == 1) fin = 1'b1;
            left--;
            return;
        end
        if (ph == PH_CDATA) begin
            left--;
            if (left == 0) begin ph = PH_CSIZE; line_reset(); end
            put(KIND_BODY, c, 1'b0, 16'd0, 1'b0, 1'b0);
            return;
        end
        if (c == 8'd0) begin fail(ERR_PROTOCOL); return; end
        if (cr) begin
            cr = 1'b0;
            if (c == CH_LF) begin end_line(); return; end
            eat(CH_CR);
        end
        if (c == CH_CR) begin cr = 1'b1; return; end
        if (c == CH_LF) begin end_line(); return; end
        eat(c);
    endtask

    task automatic compare_result();
        deframe_out_t e;
        if (expected_q.size() == 0) begin
            $error("unexpected result kind=%0d", kind);
            errors++;
            return;
        end
        e = expected_q.pop_front();
        checked++;
        if (kind !== e.kind) begin
            $error("kind exp %0d act %0d", e.kind, kind); errors++;
        end
        if (body_byte !== e.data) begin
            $error("body_byte exp %0h act %0h", e.data, body_byte); errors++;
        end
        if (body_last !== e.last) begin
            $error("body_last exp %0d act %0d", e.last, body_last); errors++;
        end
        if (status_code !== e.code) begin
            $error("status_code exp %0d act %0d", e.code, status_code); errors++;
        end
        if (http_minor !== e.minor) begin
            $error("http_minor exp %0d act %0d", e.minor, http_minor); errors++;
        end
        if (error_code !== e.err) begin
            $error("error_code exp %0d act %0d", e.err, error_code); errors++;
        end
    endtask

    initial
    begin
        errors = 0;
        checked = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit = BODY_LIMIT_RESET;
            restart_parser();
            expected_q.delete();
        end
        else
        begin
            if (out_valid && out_ready)
                compare_result();
            if (cfg_valid && cfg_ready)
                limit = cfg_data;
            if (in_valid && in_ready)
                take_request(func, rx_byte);
        end
    end

endmodule

`default_nettype wire

// File: tb/sv/http_response_deframer_top_tb.sv
`timescale 1ns / 100ps
`default_nettype none

module http_response_deframer_top_tb
    import hrd_pkg::*;
;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        func;
    logic [7:0]  rx_byte;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  kind;
    logic [7:0]  body_byte;
    logic        body_last;
    logic [15:0] status_code;
    logic        http_minor;
    logic        error_code;

    int errors, pending, checked;
    int gap_pct, stall_pct;
    int sent_bytes, responses;
    longint cycles;

    http_response_deframer_top DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .func(func), .rx_byte(rx_byte),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .out_valid(out_valid), .out_ready(out_ready),
        .kind(kind), .body_byte(body_byte), .body_last(body_last),
        .status_code(status_code), .http_minor(http_minor), .error_code(error_code)
    );

    http_response_deframer_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .func(func), .rx_byte(rx_byte),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .out_valid(out_valid), .out_ready(out_ready),
        .kind(kind), .body_byte(body_byte), .body_last(body_last),
        .status_code(status_code), .http_minor(http_minor), .error_code(error_code),
        .errors(errors), .pending(pending), .checked(checked)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // one request; entered and left at a rising edge
    task automatic send(input logic f, input logic [7:0] b);
        logic acc;
        if ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        rx_byte  <= b;
        do
        begin
            @(negedge clk);
            acc = in_ready;
            @(posedge clk);
        end while (!acc);
        sent_bytes++;
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++)
            send(1'b0, s[i]);
    endtask

    task automatic crlf_line(input string s);
        send_str(s);
        send(1'b0, CH_CR);
        send(1'b0, CH_LF);
    endtask

    task automatic restart_req();
        send(1'b1, 8'($urandom));
        responses++;
    endtask

    task automatic write_limit(input logic [31:0] v);
        logic acc;
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
        begin
            @(negedge clk);
            acc = cfg_ready;
            @(posedge clk);
        end while (!acc);
        cfg_valid <= 1'b0;
    endtask

    task automatic add(ref logic [7:0] q[$], input string s);
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
    endtask

    task automatic add_eol(ref logic [7:0] q[$]);
        if ($urandom_range(3) != 0)
            q.push_back(CH_CR);
        q.push_back(CH_LF);
    endtask

    task automatic add_data(ref logic [7:0] q[$], input int n);
        for (int i = 0; i < n; i++)
            q.push_back(8'($urandom));
    endtask

    task automatic random_response();
        logic [7:0] q[$];
        string ws[4] = '{" ", "\t", "  ", "\v\f"};
        string sp[4] = '{"chunked", "Chunked", "CHUNKED", "chunkeD"};
        int r, len;
        r = $urandom_range(19);
        if (r == 0)
        begin
            add(q, "HTTP/1.1 100 Continue"); add_eol(q);
            if ($urandom_range(1)) begin add(q, "Foo: bar"); add_eol(q); end
            add_eol(q);
        end
        if (r == 1) add(q, "HTTP/2.0 200");
        else if (r == 2) add(q, "HTTP/1.1 -5");
        else if (r == 3) add(q, $sformatf("HTTP/1.0 %0d", $urandom_range(999999999)));
        else
        begin
            add(q, $sformatf("HTTP/1.%0d%s%0d", $urandom_range(1), ws[$urandom_range(3)],
                             $urandom_range(599, 101)));
            if ($urandom_range(1)) add(q, " OK");
        end
        add_eol(q);
        repeat ($urandom_range(2))
        begin
            r = $urandom_range(15);
            if (r == 0) add(q, "NoColonHere");
            else if (r == 1) add(q, "Empty:   ");
            else add(q, $sformatf("X-H%0d: v%0d", $urandom_range(9), $urandom));
            add_eol(q);
        end
        r = $urandom_range(9);
        if (r < 5)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(24);
            if ($urandom_range(11) == 0) add(q, $sformatf("Content-Length: %0da", len));
            else add(q, $sformatf("Content-Length:%s%0d",
                                  $urandom_range(1) ? " " : "", len));
            add_eol(q); add_eol(q);
            add_data(q, len);
        end
        else if (r < 9)
        begin
            add(q, {"Transfer-Encoding: ", sp[$urandom_range(3)]}); add_eol(q); add_eol(q);
            repeat ($urandom_range(3, 1))
            begin
                len = $urandom_range(14, 1);
                add(q, $sformatf("%s%s%0x", $urandom_range(2) == 0 ? " " : "",
                                 $urandom_range(2) == 0 ? "0x" : "", len));
                if ($urandom_range(3) == 0) add(q, ";ext=1");
                add_eol(q);
                add_data(q, len);
                add_eol(q);
            end
            add(q, "0"); add_eol(q);
            if ($urandom_range(1)) begin add(q, "Trailer: t"); add_eol(q); end
            add_eol(q);
        end
        else
            add_eol(q);
        if ($urandom_range(7) == 0)
            q[$urandom_range(q.size() - 1)] = 8'($urandom);
        if ($urandom_range(4) == 0)
            add_data(q, $urandom_range(4, 1));
        restart_req();
        foreach (q[i])
            send(1'b0, q[i]);
    endtask

    task automatic random_phase(input int target);
        int start;
        start = sent_bytes;
        while (sent_bytes - start < target)
            random_response();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = 1'b0;
        rx_byte = 8'd0;
        cfg_valid = 1'b0;
        cfg_data = 32'd0;
        out_ready = 1'b0;
        gap_pct = 13;
        stall_pct = 53;
        sent_bytes = 0;
        responses = 0;
        cycles = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default limit first, then a small one
        crlf_line("HTTP/1.1 200 OK");
        crlf_line("Content-Length: 3");
        crlf_line("");
        send(1'b0, 8'h00); send(1'b0, 8'hFF); send(1'b0, 8'h5A);
        send_str("zz");
        write_limit(32'd20);

        restart_req();
        send_str("HTTP/1.0\t404\nContent-Length: 0\n\n");
        restart_req();
        crlf_line("HTTP/1.1 100 Continue");
        crlf_line("");
        crlf_line("HTTP/1.1 201");
        crlf_line("Transfer-Encoding: CHUNKED");
        crlf_line("");
        crlf_line(" 0x2;x");
        send_str("ab");
        crlf_line("");
        crlf_line("0X");
        crlf_line("Foot: 1");
        crlf_line("");
        restart_req();
        crlf_line("HTTP/1.1 +200");
        restart_req();
        crlf_line("HTTP/1.1 65536000");
        crlf_line("Foo");
        restart_req();
        crlf_line("HTTP/1.1 200");
        crlf_line("Content-Length: 99");
        crlf_line("");
        restart_req();
        crlf_line("HTTP/1.1 200");
        send_str("X: a"); send(1'b0, CH_CR); send_str("b");
        crlf_line("");
        crlf_line("");
        restart_req();
        crlf_line("HTTP/1.1 200");
        crlf_line("Content-Length: 5");
        crlf_line("Content-Length: 1x");
        crlf_line("");
        restart_req();
        send_str("HTTP/1.1 2");
        send(1'b0, 8'h00);
        restart_req();
        crlf_line("HTTP/1.1 200");
        crlf_line("Transfer-Encoding: chunked");
        crlf_line("");
        crlf_line("   ");
        restart_req();
        crlf_line("HTTP/1.1 200");
        crlf_line("Transfer-Encoding: chunked");
        crlf_line("");
        crlf_line("-1");

        write_limit(32'hFFFF_FFFF);
        restart_req();
        crlf_line("HTTP/1.1 200");
        crlf_line("Content-Length: 99999999999");
        crlf_line("");
        send_str("q");

        write_limit(32'd0);
        random_phase(60);
        write_limit(32'd16);
        random_phase(60);

        gap_pct = 53;
        stall_pct = 13;
        write_limit(32'hFFFF_FFFF);
        random_phase(120);

        gap_pct = 0;
        stall_pct = 0;
        write_limit(32'd12);
        random_phase(120);

        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (10) @(posedge clk);
        $display("Sent %0d bytes in %0d responses; %0d results checked over six limits.",
                 sent_bytes, responses, checked);
        if (errors == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
